[design/sars_pkg.sv]
// shared types and constants for the suffix array range search block
// no dependencies
`default_nettype none
package sars_pkg;
	localparam int TextDepth = 65536;
	localparam int TextAw    = 16;
	localparam int SufDepth  = 65536;
	localparam int SufAw     = 16;
	localparam int KeyMax    = 64;
	localparam int KeyAw     = 6;
	localparam int KeyCw     = 7;

	typedef enum logic [1:0] {
		OP_TEXT = 2'd0,
		OP_SUF  = 2'd1,
		OP_KEY  = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	// outcome of one key compare against a suffix
	typedef enum logic [1:0] {
		CMP_EQ   = 2'd0,
		CMP_LT   = 2'd1,
		CMP_GT   = 2'd2,
		CMP_NONE = 2'd3
	} cmp_t;

	// command handed from front to back
	typedef struct packed {
		logic [15:0] lo;
		logic [15:0] hi;
		logic [KeyCw-1:0] klen;
		logic        ovf;
	} cmd_t;

	typedef struct packed {
		logic        found;
		logic [15:0] first;
		logic [15:0] last;
		logic        ovf;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE, S_BMID, S_BSUF, S_BCMP, S_BTXT, S_BDONE,
		S_LSUF, S_LCMP, S_LTXT, S_LDONE, S_OUT
	} bst_t;
endpackage
`default_nettype wire

[design/sars_ram.sv]
// generic single port write, single port registered read memory
// no dependencies
`default_nettype none
module sars_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[design/sars_front.sv]
// front end: accepts items, counts key bytes, issues search commands
// depends on sars_pkg
`default_nettype none
module sars_front import sars_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       op,
	input  wire logic             key_last,
	input  wire logic [15:0]      range_first,
	input  wire logic [15:0]      range_final,
	input  wire logic             back_busy,
	output logic                  key_we,
	output logic [KeyAw-1:0]      key_waddr,
	output logic                  cmd_valid,
	input  wire logic             cmd_ready,
	output cmd_t                  cmd
);
	logic [KeyCw-1:0] kcnt_q;
	logic             ovf_q;
	logic             acc, is_key, fits;

	// no transfer while a search is queued or running: back end reads all three memories
	assign in_ready  = !cmd_valid && !back_busy;
	assign acc       = in_valid && in_ready;
	assign is_key    = op == OP_KEY;
	assign fits      = kcnt_q < KeyCw'(KeyMax);
	assign key_we    = acc && is_key && fits;
	assign key_waddr = kcnt_q[KeyAw-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kcnt_q    <= '0;
			ovf_q     <= 1'b0;
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ready) cmd_valid <= 1'b0;
			if (acc && is_key) begin
				if (key_last) begin
					kcnt_q    <= '0;
					ovf_q     <= 1'b0;
					cmd_valid <= 1'b1;
				end else if (fits) begin
					kcnt_q <= kcnt_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && is_key && key_last) begin
			cmd.lo     <= range_first;
			cmd.hi     <= range_final;
			cmd.klen   <= fits ? kcnt_q + 1'b1 : kcnt_q;
			cmd.ovf    <= ovf_q || !fits;
		end
	end
endmodule
`default_nettype wire

[design/sars_back.sv]
// back end: binary search then linear widening over the suffix array
// depends on sars_pkg
`default_nettype none
module sars_back import sars_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [16:0]      text_length,
	input  wire logic             cmd_valid,
	output logic                  cmd_ready,
	output logic                  busy,
	input  cmd_t                  cmd,
	output logic [SufAw-1:0]      suf_raddr,
	input  wire logic [15:0]      suf_rdata,
	output logic [TextAw-1:0]     txt_raddr,
	input  wire logic [7:0]       txt_rdata,
	output logic [KeyAw-1:0]      key_raddr,
	input  wire logic [7:0]       key_rdata,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output res_t                  res
);
	bst_t st_q, st_n;
	cmp_t r_q;
	logic signed [17:0] lo_q, hi_q, mid_q, pos_q;
	logic signed [17:0] nlo, nhi, rlo_s, rhi_s;
	logic [15:0] rlo_q, rhi_q, hit_q;
	logic [KeyCw-1:0] klen_q, i_q;
	logic [16:0] off_q;
	logic        dir_q;
	logic [17:0] lim, p;
	logic        past, in_rng;

	assign lim = (text_length > 17'(TextDepth)) ? 18'(TextDepth) : {1'b0, text_length};
	assign p   = {1'b0, off_q} + 18'(i_q);
	assign past = p >= lim;
	assign suf_raddr = (st_q == S_BMID) ? mid_q[15:0] : pos_q[15:0];
	assign txt_raddr = p[TextAw-1:0];
	assign key_raddr = i_q[KeyAw-1:0];
	// a new search overwrites the result, so the previous one must be taken first
	assign cmd_ready = (st_q == S_IDLE) && (!res_valid || res_ready);
	assign busy      = st_q != S_IDLE;

	// bounds after the last binary probe
	assign nlo   = (r_q == CMP_GT) ? mid_q + 18'sd1 : lo_q;
	assign nhi   = (r_q == CMP_LT) ? mid_q - 18'sd1 : hi_q;
	assign rlo_s = $signed({2'b00, rlo_q});
	assign rhi_s = $signed({2'b00, rhi_q});
	assign in_rng = dir_q ? (pos_q <= rhi_s) : (pos_q >= rlo_s);

	always_comb begin
		st_n = st_q;
		case (st_q)
			S_IDLE:  if (cmd_valid && cmd_ready) st_n = S_BDONE;
			S_BDONE: begin
				if (r_q == CMP_EQ) st_n = S_LDONE;
				else if (nlo <= nhi) st_n = S_BMID;
				else st_n = S_OUT;
			end
			S_BMID:  st_n = S_BSUF;
			S_BSUF:  st_n = S_BCMP;
			S_BCMP:  st_n = (i_q == klen_q || past) ? S_BDONE : S_BTXT;
			S_BTXT:  st_n = (txt_rdata != key_rdata || i_q + 1'b1 == klen_q)
				? S_BDONE : S_BCMP;
			S_LDONE: begin
				if (r_q == CMP_EQ) st_n = S_LDONE;
				else if (r_q == CMP_NONE && in_rng) st_n = S_LSUF;
				else if (!dir_q) st_n = S_LDONE;
				else st_n = S_OUT;
			end
			S_LSUF:  st_n = S_LCMP;
			S_LCMP:  st_n = (i_q == klen_q || past) ? S_LDONE : S_LTXT;
			S_LTXT:  st_n = (txt_rdata != key_rdata || i_q + 1'b1 == klen_q)
				? S_LDONE : S_LCMP;
			S_OUT:   st_n = S_IDLE;
			default: st_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			res_valid <= 1'b0;
		end else begin
			st_q <= st_n;
			if (st_q == S_OUT) res_valid <= 1'b1;
			else if (res_ready) res_valid <= 1'b0;
		end
	end

	// compare loop fills r_q; done states consume it
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: if (cmd_valid && cmd_ready) begin
				lo_q <= $signed({2'b00, cmd.lo}); hi_q <= $signed({2'b00, cmd.hi});
				rlo_q <= cmd.lo; rhi_q <= cmd.hi;
				klen_q <= cmd.klen;
				res.found <= 1'b0; res.first <= '0; res.last <= '0; res.ovf <= cmd.ovf;
				r_q <= CMP_NONE;
			end
			S_BDONE: begin
				if (r_q == CMP_EQ) begin
					hit_q <= mid_q[15:0];
					res.found <= 1'b1;
					res.first <= mid_q[15:0];
					res.last  <= mid_q[15:0];
					dir_q <= 1'b0;
					pos_q <= mid_q - 18'sd1;
					r_q <= CMP_NONE;
				end else begin
					lo_q  <= nlo;
					hi_q  <= nhi;
					mid_q <= (nlo + nhi) >>> 1;
				end
			end
			S_BMID: i_q <= '0;
			S_BSUF: off_q <= {1'b0, suf_rdata};
			S_LSUF: begin
				i_q   <= '0;
				off_q <= {1'b0, suf_rdata};
			end
			S_BCMP, S_LCMP: begin
				if (i_q == klen_q) r_q <= CMP_EQ;
				else if (past) r_q <= CMP_GT;
			end
			S_BTXT, S_LTXT: begin
				if (key_rdata < txt_rdata) r_q <= CMP_LT;
				else if (key_rdata > txt_rdata) r_q <= CMP_GT;
				else if (i_q + 1'b1 == klen_q) r_q <= CMP_EQ;
				i_q <= i_q + 1'b1;
			end
			S_LDONE: begin
				if (r_q == CMP_EQ) begin
					// widen the match and step on
					if (dir_q) res.last <= pos_q[15:0];
					else       res.first <= pos_q[15:0];
					pos_q <= dir_q ? pos_q + 18'sd1 : pos_q - 18'sd1;
					r_q <= CMP_NONE;
				end else if (r_q != CMP_NONE || !in_rng) begin
					// a scan ended; after the lower scan, turn to the upper side of the hit
					if (!dir_q) begin
						dir_q <= 1'b1;
						pos_q <= $signed({2'b00, hit_q}) + 18'sd1;
						r_q <= CMP_NONE;
					end
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[design/suffix_array_range_search.sv]
// top level of the suffix array range search block
// depends on sars_pkg, sars_ram, sars_front, sars_back
// Text byte loads, suffix entry loads and key bytes are taken one per cycle while no
// search is pending. A final key byte queues one search and holds the input off until
// the back end has finished it; a result not yet taken also holds off the next search.
// A search starts from the idle state; each probe, binary or linear, reads one suffix entry
// and compares key bytes with text one at a time, and the output state issues the result.
// The binary search needs about log2 of the range length probes, the linear widening one
// probe per matching entry plus at most one past each end. One result is given per search.
`default_nettype none
module suffix_array_range_search import sars_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [16:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata, // op, address, data, range_first, range_final
	input  wire logic        s_tlast, // key_last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata  // found, first_match_res, last_match, key_overflow
);
	logic [16:0] tlen_q;
	logic key_we, cmd_valid, cmd_ready, acc, back_busy;
	logic [KeyAw-1:0] key_waddr, key_raddr;
	cmd_t cmd;
	res_t res;
	logic [15:0] suf_raddr, suf_rdata;
	logic [TextAw-1:0] txt_raddr;
	logic [7:0] txt_rdata, key_rdata;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tlen_q <= '0;
		else if (cfg_valid) tlen_q <= cfg_data;
	end

	assign acc = s_tvalid && s_tready;

	sars_front u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.op(s_tdata[1:0]), .key_last(s_tlast),
		.range_first(s_tdata[49:34]), .range_final(s_tdata[65:50]),
		.back_busy, .key_we, .key_waddr, .cmd_valid, .cmd_ready, .cmd
	);

	sars_ram #(.Width(8), .Depth(TextDepth)) u_text (
		.clk, .we(acc && s_tdata[1:0] == OP_TEXT), .waddr(s_tdata[17:2]),
		.wdata(s_tdata[25:18]), .raddr(txt_raddr), .rdata(txt_rdata)
	);
	sars_ram #(.Width(16), .Depth(SufDepth)) u_suf (
		.clk, .we(acc && s_tdata[1:0] == OP_SUF), .waddr(s_tdata[17:2]),
		.wdata(s_tdata[33:18]), .raddr(suf_raddr), .rdata(suf_rdata)
	);
	sars_ram #(.Width(8), .Depth(KeyMax)) u_key (
		.clk, .we(key_we), .waddr(key_waddr), .wdata(s_tdata[25:18]),
		.raddr(key_raddr), .rdata(key_rdata)
	);

	sars_back u_back (
		.clk, .arst_n, .text_length(tlen_q), .cmd_valid, .cmd_ready, .busy(back_busy), .cmd,
		.suf_raddr, .suf_rdata, .txt_raddr, .txt_rdata, .key_raddr, .key_rdata,
		.res_valid(m_tvalid), .res_ready(m_tready), .res
	);

	assign m_tdata = {6'd0, res.ovf, res.last, res.first, res.found};
endmodule
`default_nettype wire

[design/sars_checker.sv]
// port level checker for suffix_array_range_search
// depends on suffix_array_range_search ports only
`default_nettype none
module sars_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'd0) else $error("miss");
	a_ord: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[16:1] <= m_tdata[32:17]) else $error("order");
endmodule
bind suffix_array_range_search sars_checker u_chk (
	.clk, .arst_n, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire

[test/tb_suffix_array_range_search.sv]
// self-checking testbench for suffix_array_range_search: loads text and suffix
// entries, sends keys over sorted and noisy ranges, predicts every search result
// depends on sars_pkg and the suffix_array_range_search rtl
`default_nettype none
module tb_suffix_array_range_search import sars_pkg::*; ();

	typedef struct {
		logic        found;
		logic [15:0] first;
		logic [15:0] last;
		logic        ovf;
	} search_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [16:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	suffix_array_range_search dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// shadow state of the block
	logic [7:0]  text_mem [TextDepth];
	logic [15:0] sa_mem [65536];
	logic [7:0]  key_buf [KeyMax];
	int unsigned key_cnt = 0;
	bit          key_ovf = 0;
	int unsigned text_len = 0;

	search_res_t pending_res [$];
	int          errors = 0;
	bit          idle_en = 1;
	int          hold_cycles = 0;

	// receiver side
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else if (!idle_en) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 8);
		end
	end

	// result checker, sampled on the falling edge before the transfer edge
	always @(negedge clk) begin
		search_res_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_res.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $time, m_tdata);
			end else begin
				exp_r = pending_res.pop_front();
				if (m_tdata[0] !== exp_r.found || m_tdata[16:1] !== exp_r.first ||
				    m_tdata[32:17] !== exp_r.last || m_tdata[33] !== exp_r.ovf) begin
					errors++;
					$display("%0t: expected found=%0d first=%0d last=%0d ovf=%0d, got found=%0d first=%0d last=%0d ovf=%0d",
						$time, exp_r.found, exp_r.first, exp_r.last, exp_r.ovf,
						m_tdata[0], m_tdata[16:1], m_tdata[32:17], m_tdata[33]);
				end
			end
		end
	end

	function automatic int key_vs_text(int unsigned off);
		int unsigned lim;
		int diff;
		lim = (text_len > TextDepth) ? TextDepth : text_len;
		diff = 0;
		for (int unsigned i = 0; i < key_cnt; i++) begin
			if (off + i >= lim) return 1;
			diff = int'(key_buf[i]) - int'(text_mem[off + i]);
			if (diff != 0) return diff;
		end
		return diff;
	endfunction

	function automatic int key_vs_entry(int idx);
		return key_vs_text(sa_mem[idx & 16'hFFFF]);
	endfunction

	function automatic search_res_t range_search(int lo_in, int hi_in);
		search_res_t r;
		int lo, hi, hit, mid, c, a, b;
		lo = lo_in;
		hi = hi_in;
		hit = -1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			c = key_vs_entry(mid);
			if (c < 0) hi = mid - 1;
			else if (c > 0) lo = mid + 1;
			else begin
				hit = mid;
				break;
			end
		end
		r.ovf = key_ovf;
		if (hit < 0) begin
			r.found = 0;
			r.first = 0;
			r.last = 0;
		end else begin
			a = hit - 1;
			while (a >= lo_in && key_vs_entry(a) == 0) a--;
			b = hit + 1;
			while (b <= hi_in && key_vs_entry(b) == 0) b++;
			r.found = 1;
			r.first = 16'(a + 1);
			r.last = 16'(b - 1);
		end
		return r;
	endfunction

	task automatic send_item(op_t op, logic [15:0] addr, logic [15:0] data, bit last,
			logic [15:0] rf, logic [15:0] rl);
		logic [71:0] word;
		bit acc;
		if (idle_en && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		word = {6'b0, rl, rf, data, addr, op};
		s_tdata <= word;
		s_tlast <= last;
		s_tvalid <= 1'b1;
		do begin
			@(negedge clk);
			acc = s_tready;
			@(posedge clk);
		end while (!acc);
		case (op)
			OP_TEXT: text_mem[addr] = data[7:0];
			OP_SUF: sa_mem[addr] = data;
			OP_KEY: begin
				if (key_cnt < KeyMax) begin
					key_buf[key_cnt] = data[7:0];
					key_cnt++;
				end else begin
					key_ovf = 1;
				end
				if (last) begin
					pending_res.push_back(range_search(rf, rl));
					key_cnt = 0;
					key_ovf = 0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_text_len(int unsigned v);
		bit acc;
		wait_idle();
		cfg_data <= 17'(v);
		cfg_valid <= 1'b1;
		do begin
			@(negedge clk);
			acc = cfg_ready;
			@(posedge clk);
		end while (!acc);
		cfg_valid <= 1'b0;
		text_len = v;
	endtask

	task automatic send_key(logic [7:0] kb [$], logic [15:0] rf, logic [15:0] rl);
		for (int i = 0; i < kb.size(); i++)
			send_item(OP_KEY, 16'($urandom), {8'($urandom), kb[i]}, i == kb.size() - 1,
				(i == kb.size() - 1) ? rf : 16'($urandom),
				(i == kb.size() - 1) ? rl : 16'($urandom));
	endtask

	function automatic int suffix_order(int unsigned p, int unsigned q);
		int unsigned lim;
		lim = (text_len > TextDepth) ? TextDepth : text_len;
		for (int unsigned i = 0; i < 80; i++) begin
			if (p + i >= lim && q + i >= lim) return 0;
			if (p + i >= lim) return -1;
			if (q + i >= lim) return 1;
			if (text_mem[p + i] != text_mem[q + i])
				return (text_mem[p + i] < text_mem[q + i]) ? -1 : 1;
		end
		return 0;
	endfunction

	// one region of text and suffix entries, then searches with some noise mixed in
	task automatic run_region(int tbase, int tlen, int len, int sbase, int n, int nsearch);
		int unsigned starts [$];
		int unsigned tmp;
		logic [7:0] kb [$];
		int lo, hi, st, klen, sel;
		write_text_len(len);
		for (int i = 0; i < tlen; i++)
			send_item(OP_TEXT, 16'(tbase + i),
				{8'($urandom), ($urandom_range(9) == 0) ? 8'($urandom) : 8'(97 + $urandom_range(2))},
				$urandom_range(1), 16'($urandom), 16'($urandom));
		for (int i = 0; i < tlen; i++) starts.push_back(tbase + i);
		for (int i = 1; i < starts.size(); i++)
			for (int j = i; j > 0 && suffix_order(starts[j - 1], starts[j]) > 0; j--) begin
				tmp = starts[j];
				starts[j] = starts[j - 1];
				starts[j - 1] = tmp;
			end
		for (int i = 0; i < n; i++) begin
			// occasional entry past the text end compares as key greater
			if (len < TextDepth && $urandom_range(15) == 0)
				tmp = $urandom_range(65535, len);
			else
				tmp = starts[i % starts.size()];
			send_item(OP_SUF, 16'(sbase + i), 16'(tmp), $urandom_range(1),
				16'($urandom), 16'($urandom));
		end
		for (int s = 0; s < nsearch; s++) begin
			sel = $urandom_range(99);
			if (sel < 4)
				send_item(OP_TEXT, 16'(tbase + $urandom_range(tlen - 1)), 16'($urandom),
					$urandom_range(1), 16'($urandom), 16'($urandom));
			else if (sel < 8)
				send_item(OP_SUF, 16'(sbase + $urandom_range(n - 1)),
					16'(tbase + $urandom_range(tlen - 1)), $urandom_range(1),
					16'($urandom), 16'($urandom));
			else if (sel < 10)
				send_item(OP_NOP, 16'($urandom), 16'($urandom), $urandom_range(1),
					16'($urandom), 16'($urandom));
			kb.delete();
			sel = $urandom_range(99);
			if (sel < 5) klen = $urandom_range(70, 60);
			else klen = $urandom_range(4, 1);
			if (sel >= 5 && sel < 15) begin
				for (int i = 0; i < klen; i++) kb.push_back(8'($urandom));
			end else begin
				st = tbase + $urandom_range(tlen - 1);
				// only text written in this region feeds the key
				for (int i = 0; i < klen; i++)
					kb.push_back((st + i < tbase + tlen) ? text_mem[st + i] : 8'(97));
				if ($urandom_range(4) == 0)
					kb[$urandom_range(klen - 1)] = 8'(97 + $urandom_range(2));
			end
			sel = $urandom_range(99);
			if (sel < 40) begin
				lo = sbase;
				hi = sbase + n - 1;
			end else begin
				lo = sbase + $urandom_range(n - 1);
				hi = sbase + $urandom_range(n - 1);
				if (sel < 50) begin
					if (lo <= hi && lo != hi) begin
						tmp = lo;
						lo = hi;
						hi = tmp;
					end
				end else if (lo > hi) begin
					tmp = lo;
					lo = hi;
					hi = tmp;
				end
			end
			send_key(kb, 16'(lo), 16'(hi));
		end
	endtask

	task automatic test_directed();
		logic [7:0] kb [$];
		write_text_len(0);
		for (int i = 0; i < 8; i++)
			send_item(OP_TEXT, 16'(i), {8'hA5, 8'(97 + (i & 1))}, 0, 16'hFFFF, 16'hFFFF);
		for (int i = 0; i < 8; i++)
			send_item(OP_SUF, 16'(i), 16'(i), 0, 16'h0, 16'h0);
		kb = '{8'd97};
		send_key(kb, 16'd0, 16'd7);  // text length zero: always a miss
		write_text_len(8);
		send_key(kb, 16'd0, 16'd7);
		kb = '{8'd97, 8'd98};
		send_key(kb, 16'd0, 16'd7);
		kb = '{8'hFF};
		send_key(kb, 16'd0, 16'd7);
		kb = '{8'h00};
		send_key(kb, 16'd3, 16'd3);
		kb = '{8'd98};
		send_key(kb, 16'd5, 16'd2);  // empty range
		// key_last on writes gives no result
		send_item(OP_TEXT, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF);
		send_item(OP_SUF, 16'hFFFF, 16'd2, 1, 16'hFFFF, 16'hFFFF);
		send_item(OP_NOP, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF);
		kb = '{8'd97};
		send_key(kb, 16'hFFFF, 16'hFFFF);
		send_key(kb, 16'hFFFF, 16'h0000);
		wait_idle();
	endtask

	task automatic test_low_region();
		run_region(0, 32, 32, 0, 32, 45);
		run_region(0, 40, 25, 100, 40, 45);
	endtask

	task automatic test_top_region();
		run_region(65536 - 32, 32, 65536, 65536 - 32, 32, 45);
	endtask

	task automatic test_no_idle();
		idle_en = 0;
		run_region(0, 24, 24, 300, 24, 40);
		idle_en = 1;
	endtask

	task automatic test_backpressure();
		logic [7:0] kb [$];
		write_text_len(32);
		idle_en = 0;
		hold_cycles = 600;
		for (int i = 0; i < 40; i++) begin
			kb = '{8'(97 + $urandom_range(2))};
			send_key(kb, 16'd0, 16'd31);
		end
		idle_en = 1;
		wait_idle();
		run_region(0, 32, 32, 0, 32, 30);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_low_region();
		test_top_region();
		test_no_idle();
		test_backpressure();
		wait_idle();
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#200000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
